FILE: rtl/core/oatr_pkg.sv
`default_nettype none

package oatr_pkg;

   // storage and arithmetic sizes
   localparam int TABLE_DEPTH    = 65536;
   localparam int WEIGHT_STEPS   = 256;
   localparam int SAMPLE_BITS    = 16;
   localparam int ADDR_BITS      = $clog2(TABLE_DEPTH);
   localparam int WIDX_BITS      = $clog2(WEIGHT_STEPS + 1);
   localparam int WEIGHT_BITS    = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_END    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_STEP  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LUT_STEP     = 2'd3;

   // play control constants
   localparam int SILENT_LIMIT = 1024;
   localparam int MIN_STEP     = 66;
   localparam logic [24:0] HALF_PHASE = 25'((WEIGHT_STEPS / 2) * 65536);
   localparam logic [24:0] PHASE_MAX  = '1;
   localparam logic [32:0] SECOND_RESET_OFFSET = 33'(512 * 65536);

   // max step = floor(width * 65536 * 49 / 100) = floor(width * 802816 / 25)
   localparam int MAXST_MUL    = 49 * 16384;
   localparam int MAXST_DIV    = 25;
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_MUL    = ((1 << RECIP_SHIFT) + MAXST_DIV - 1) / MAXST_DIV;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef logic [19:0] rem_table_type [0:31];
   typedef logic [WEIGHT_BITS-1:0] weight_rom_type [0:WEIGHT_STEPS];

   // derived configuration seen by the play path
   typedef struct packed {
      logic        ready;
      logic        silent;
      logic [16:0] span;
      logic [32:0] window_q;
      logic [32:0] half_window;
      logic [30:0] step;
      logic [22:0] lut_step;
   } oatr_cfg_type;

   // one window's read point
   typedef struct packed {
      logic [ADDR_BITS-1:0]   addr_lo;
      logic [ADDR_BITS-1:0]   addr_hi;
      logic [15:0]            frac;
      logic [WEIGHT_BITS-1:0] weight;
   } oatr_tap_type;

   // window state updates
   typedef struct packed {
      logic restart;
      logic advance;
   } oatr_win_ctrl_type;

   // mix datapath strobes
   typedef struct packed {
      logic cap_a1;
      logic cap_b1;
      logic cap_a2;
      logic cap_b2;
      logic mul_en;
      logic wgt_en;
      logic second;
   } oatr_mix_ctrl_type;

   // floor of remainder * 802816 / 25 for each remainder of width / 25
   function automatic rem_table_type build_rem_table();
      rem_table_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 20'((i * MAXST_MUL) / MAXST_DIV);
      end
      return t;
   endfunction

   // raised-cosine weights from a truncated sine series in Q30
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type     rom;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        sq;
      logic [63:0]        w;
      logic signed [63:0] s;
      int                 kk;
      for (int k = 0; k <= WEIGHT_STEPS; k++) begin
         kk = (k <= WEIGHT_STEPS - k) ? k : WEIGHT_STEPS - k;
         x = (PI_Q30 * 64'(kk)) / WEIGHT_STEPS;
         x2 = (x * x) >> 30;
         s = $signed(x);
         term = ((x * x2) >> 30) / 6;
         s = s - $signed(term);
         term = ((term * x2) >> 30) / 20;
         s = s + $signed(term);
         term = ((term * x2) >> 30) / 42;
         s = s - $signed(term);
         term = ((term * x2) >> 30) / 72;
         s = s + $signed(term);
         term = ((term * x2) >> 30) / 110;
         s = s - $signed(term);
         if (s < 0) s = 0;
         if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
         sq = $unsigned(s) * $unsigned(s);
         w = (sq + (64'd1 << 44)) >> 45;
         if (w > 64'd32768) w = 64'd32768;
         rom[k] = WEIGHT_BITS'(w);
      end
      return rom;
   endfunction

   localparam rem_table_type  REM_TABLE  = build_rem_table();
   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

endpackage

`default_nettype wire

FILE: rtl/core/oatr_channel_if.sv
`default_nettype none

// input item channel
interface oatr_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [15:0]        position;
   logic [15:0]        table_address;
   logic signed [15:0] table_data;

   modport source (output valid, mode, position, table_address, table_data, input ready);
   modport sink (input valid, mode, position, table_address, table_data, output ready);
endinterface

// result item channel
interface oatr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/oatr_ram.sv
`default_nettype none

module oatr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] read_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/oatr_cfg.sv
`default_nettype none

module oatr_cfg
   import oatr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] index,
   input  wire logic [CSR_DATA_BITS-1:0]  write_data,
   output oatr_cfg_type                   cfg
);

   localparam int DERIVE_CYCLES = 4;
   localparam int COUNT_BITS    = $clog2(DERIVE_CYCLES + 1);

   logic [16:0] table_end_ff, table_end_in;
   logic [16:0] window_width_ff, window_width_in;
   logic [30:0] window_step_ff, window_step_in;
   logic [22:0] lut_step_ff, lut_step_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [38:0] recip_prod_ff, recip_prod_in;
   logic [12:0] quot_ff, quot_in;
   logic [4:0]  rem_ff, rem_in;
   logic [32:0] max_step_ff, max_step_in;
   logic [30:0] step_ff, step_in;

   logic [12:0] quot_raw;
   logic [16:0] rem_wide;
   logic [30:0] step_floor;

   // register writes
   always_comb begin
      table_end_in    = table_end_ff;
      window_width_in = window_width_ff;
      window_step_in  = window_step_ff;
      lut_step_in     = lut_step_ff;
      if (write_enable) begin
         case (index)
            CSR_TABLE_END:    table_end_in    = write_data[16:0];
            CSR_WINDOW_WIDTH: window_width_in = write_data[16:0];
            CSR_WINDOW_STEP:  window_step_in  = write_data[30:0];
            CSR_LUT_STEP:     lut_step_in     = write_data[22:0];
            default: ;
         endcase
      end
   end

   // hold off items until the derived step has settled
   always_comb begin
      if (write_enable) begin
         count_in = COUNT_BITS'(DERIVE_CYCLES);
      end else if (count_ff != '0) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // width / 25 by reciprocal, then remainder with one correction
   always_comb begin
      recip_prod_in = 39'(window_width_ff) * 39'(RECIP_MUL);
      quot_raw = recip_prod_ff[RECIP_SHIFT +: 13];
      rem_wide = window_width_ff - 17'(17'(quot_raw) * 17'(MAXST_DIV));
      if (rem_wide >= 17'(MAXST_DIV)) begin
         quot_in = quot_raw + 13'd1;
         rem_in  = 5'(rem_wide - 17'(MAXST_DIV));
      end else begin
         quot_in = quot_raw;
         rem_in  = 5'(rem_wide);
      end
   end

   // step limit and clamped step
   always_comb begin
      max_step_in = 33'(33'(quot_ff) * 33'(MAXST_MUL)) + 33'(REM_TABLE[rem_ff]);
      step_floor = (window_step_ff < 31'(MIN_STEP)) ? 31'(MIN_STEP) : window_step_ff;
      step_in = (33'(step_floor) > max_step_ff) ? max_step_ff[30:0] : step_floor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_end_ff    <= '0;
         window_width_ff <= 17'd1024;
         window_step_ff  <= 31'd65536;
         lut_step_ff     <= 23'd16384;
         count_ff        <= COUNT_BITS'(DERIVE_CYCLES);
      end else begin
         table_end_ff    <= table_end_in;
         window_width_ff <= window_width_in;
         window_step_ff  <= window_step_in;
         lut_step_ff     <= lut_step_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      recip_prod_ff <= recip_prod_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      max_step_ff   <= max_step_in;
      step_ff       <= step_in;
   end

   // derived values
   always_comb begin
      cfg.ready       = (count_ff == '0);
      cfg.silent      = (table_end_ff <= 17'(SILENT_LIMIT));
      cfg.span        = (table_end_ff > window_width_ff) ? table_end_ff - window_width_ff : '0;
      cfg.window_q    = {window_width_ff, 16'b0};
      cfg.half_window = {1'b0, window_width_ff, 15'b0};
      cfg.step        = step_ff;
      cfg.lut_step    = lut_step_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/core/oatr_windows.sv
`default_nettype none

module oatr_windows
   import oatr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire oatr_cfg_type      cfg,
   input  wire oatr_win_ctrl_type ctrl,
   input  wire logic [15:0]       position,
   output oatr_tap_type           first_tap,
   output oatr_tap_type           second_tap
);

   logic [32:0] first_start_ff, first_start_in;
   logic [32:0] first_offset_ff, first_offset_in;
   logic [24:0] first_phase_ff, first_phase_in;
   logic [32:0] second_start_ff, second_start_in;
   logic [32:0] second_offset_ff, second_offset_in;
   logic [24:0] second_phase_ff, second_phase_in;
   oatr_tap_type first_tap_ff, first_tap_in;
   oatr_tap_type second_tap_ff, second_tap_in;

   logic [32:0] restart_start;
   logic        first_restart;
   logic        second_restart;

   function automatic logic [24:0] phase_add(input logic [24:0] ph, input logic [22:0] inc);
      logic [25:0] sum;
      sum = 26'(ph) + 26'(inc);
      return (sum > 26'(PHASE_MAX)) ? PHASE_MAX : sum[24:0];
   endfunction

   // read point, neighbor and weight for one window
   function automatic oatr_tap_type make_tap(input logic [32:0] start,
                                             input logic [32:0] offset,
                                             input logic [24:0] phase);
      oatr_tap_type         t;
      logic [33:0]          p;
      logic [17:0]          index_wide;
      logic [8:0]           phase_index;
      logic [WIDX_BITS-1:0] widx;
      p = {1'b0, start} + {1'b0, offset};
      index_wide = p[33:16];
      if (index_wide > 18'(TABLE_DEPTH - 1)) begin
         t.addr_lo = ADDR_BITS'(TABLE_DEPTH - 1);
      end else begin
         t.addr_lo = ADDR_BITS'(index_wide);
      end
      if (t.addr_lo == ADDR_BITS'(TABLE_DEPTH - 1)) begin
         t.addr_hi = t.addr_lo;
      end else begin
         t.addr_hi = t.addr_lo + ADDR_BITS'(1);
      end
      t.frac = p[15:0];
      phase_index = phase[24:16];
      if (phase_index > 9'(WEIGHT_STEPS)) begin
         widx = WIDX_BITS'(WEIGHT_STEPS);
      end else begin
         widx = WIDX_BITS'(phase_index);
      end
      t.weight = WEIGHT_ROM[widx];
      return t;
   endfunction

   // restart checks, then advance after the read points are taken
   always_comb begin
      restart_start  = 33'(33'(position) * 33'(cfg.span));
      first_restart  = ({1'b0, first_offset_ff} + 34'(cfg.step)) > {1'b0, cfg.window_q};
      second_restart = ({1'b0, second_offset_ff} + 34'(cfg.step)) > {1'b0, cfg.window_q};

      first_start_in   = first_start_ff;
      first_offset_in  = first_offset_ff;
      first_phase_in   = first_phase_ff;
      second_start_in  = second_start_ff;
      second_offset_in = second_offset_ff;
      second_phase_in  = second_phase_ff;
      first_tap_in     = first_tap_ff;
      second_tap_in    = second_tap_ff;

      if (ctrl.restart) begin
         if (first_restart) begin
            first_start_in   = restart_start;
            first_offset_in  = '0;
            first_phase_in   = '0;
            second_offset_in = cfg.half_window;
            second_phase_in  = HALF_PHASE;
         end
         if (second_restart) begin
            second_start_in  = restart_start;
            second_offset_in = '0;
            second_phase_in  = '0;
            first_offset_in  = cfg.half_window;
            first_phase_in   = HALF_PHASE;
         end
      end

      if (ctrl.advance) begin
         first_tap_in     = make_tap(first_start_ff, first_offset_ff, first_phase_ff);
         second_tap_in    = make_tap(second_start_ff, second_offset_ff, second_phase_ff);
         first_offset_in  = first_offset_ff + 33'(cfg.step);
         second_offset_in = second_offset_ff + 33'(cfg.step);
         first_phase_in   = phase_add(first_phase_ff, cfg.lut_step);
         second_phase_in  = phase_add(second_phase_ff, cfg.lut_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_start_ff   <= '0;
         first_offset_ff  <= '0;
         first_phase_ff   <= '0;
         second_start_ff  <= SECOND_RESET_OFFSET;
         second_offset_ff <= SECOND_RESET_OFFSET;
         second_phase_ff  <= HALF_PHASE;
      end else begin
         first_start_ff   <= first_start_in;
         first_offset_ff  <= first_offset_in;
         first_phase_ff   <= first_phase_in;
         second_start_ff  <= second_start_in;
         second_offset_ff <= second_offset_in;
         second_phase_ff  <= second_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      first_tap_ff  <= first_tap_in;
      second_tap_ff <= second_tap_in;
   end

   assign first_tap  = first_tap_ff;
   assign second_tap = second_tap_ff;

endmodule

`default_nettype wire

FILE: rtl/core/oatr_mix.sv
`default_nettype none

module oatr_mix
   import oatr_pkg::*;
(
   input  wire logic                          clock,
   input  wire oatr_mix_ctrl_type             ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] read_data,
   input  wire oatr_tap_type                  first_tap,
   input  wire oatr_tap_type                  second_tap,
   output logic signed [SAMPLE_BITS-1:0]      mix_sample
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int IP_BITS   = 17 + DIFF_BITS;
   localparam int VAL_BITS  = SAMPLE_BITS + 2;
   localparam int WP_BITS   = WEIGHT_BITS + 1 + DIFF_BITS;
   localparam int ACC_BITS  = WP_BITS + 1;
   localparam int Y_BITS    = ACC_BITS - 15;
   localparam logic signed [Y_BITS-1:0] Y_MAX = Y_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Y_BITS-1:0] Y_MIN = -Y_MAX - Y_BITS'(1);

   logic signed [SAMPLE_BITS-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [IP_BITS-1:0]     interp_ff, interp_in;
   logic signed [WP_BITS-1:0]     first_wp_ff, second_wp_ff, weighted_in;

   logic signed [SAMPLE_BITS-1:0] a_sel, b_sel;
   logic [15:0]                   frac_sel;
   logic [WEIGHT_BITS-1:0]        weight_sel;
   logic signed [DIFF_BITS-1:0]   diff;
   logic signed [16:0]            frac_s;
   logic signed [VAL_BITS-1:0]    value;
   logic signed [DIFF_BITS-1:0]   value_n;
   logic signed [WEIGHT_BITS:0]   weight_s;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [Y_BITS-1:0]      y;

   // interpolate between neighbors, then weight
   always_comb begin
      a_sel      = ctrl.second ? a2_ff : a1_ff;
      b_sel      = ctrl.second ? b2_ff : b1_ff;
      frac_sel   = ctrl.second ? second_tap.frac : first_tap.frac;
      weight_sel = ctrl.second ? second_tap.weight : first_tap.weight;
      diff       = DIFF_BITS'(b_sel) - DIFF_BITS'(a_sel);
      frac_s     = $signed({1'b0, frac_sel});
      interp_in  = IP_BITS'(frac_s * diff);
      value      = VAL_BITS'(a_sel) + $signed(interp_ff[IP_BITS-1:16]);
      value_n    = value[DIFF_BITS-1:0];
      weight_s   = $signed({1'b0, weight_sel});
      weighted_in = WP_BITS'(weight_s * value_n);
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap_a1) a1_ff <= read_data;
      if (ctrl.cap_b1) b1_ff <= read_data;
      if (ctrl.cap_a2) a2_ff <= read_data;
      if (ctrl.cap_b2) b2_ff <= read_data;
      if (ctrl.mul_en) interp_ff <= interp_in;
      if (ctrl.wgt_en && !ctrl.second) first_wp_ff <= weighted_in;
      if (ctrl.wgt_en && ctrl.second) second_wp_ff <= weighted_in;
   end

   // sum, floor divide by 2^15 and saturate
   always_comb begin
      acc = ACC_BITS'(first_wp_ff) + ACC_BITS'(second_wp_ff);
      y   = $signed(acc[ACC_BITS-1:15]);
      if (y > Y_MAX) begin
         mix_sample = SAMPLE_BITS'(Y_MAX);
      end else if (y < Y_MIN) begin
         mix_sample = SAMPLE_BITS'(Y_MIN);
      end else begin
         mix_sample = y[SAMPLE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/overlap_add_table_reader.sv
`default_nettype none

// channel   direction  payload
// req_      in         mode, position, table_address, table_data
// rsp_      out        sample_out
// csr_      in         write_enable, index, write_data (31 bits)
//
// a write item goes straight to the sample memory; a play item is paced by the four reads
// of the sample memory's single read port plus restart, address, interpolate and mix steps
// a play item while the output is silent skips straight to the output step
// a register write holds off items while the step limit is derived
// reset restores registers and window state; the sample memory is not cleared
// a play item waits in its last cycle while the output register is still full
module overlap_add_table_reader
   import oatr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   oatr_req_if.sink                       req_channel,
   oatr_rsp_if.source                     rsp_channel,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CALC  = 4'd1;
   localparam logic [3:0] S_ADDR  = 4'd2;
   localparam logic [3:0] S_RD_A1 = 4'd3;
   localparam logic [3:0] S_RD_B1 = 4'd4;
   localparam logic [3:0] S_RD_A2 = 4'd5;
   localparam logic [3:0] S_RD_B2 = 4'd6;
   localparam logic [3:0] S_TAIL1 = 4'd7;
   localparam logic [3:0] S_MUL2  = 4'd8;
   localparam logic [3:0] S_WGT2  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic               silent_ff, silent_in;
   logic [15:0]        position_ff, position_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;

   oatr_cfg_type      cfg;
   oatr_win_ctrl_type win_ctrl;
   oatr_mix_ctrl_type mix_ctrl;
   oatr_tap_type      first_tap, second_tap;

   logic                          accept;
   logic                          slot_free;
   logic                          mem_write;
   logic [ADDR_BITS-1:0]          read_address;
   logic [SAMPLE_BITS-1:0]        read_data;
   logic signed [SAMPLE_BITS-1:0] mix_sample;

   oatr_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   oatr_windows u_windows (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ctrl       (win_ctrl),
      .position   (position_ff),
      .first_tap  (first_tap),
      .second_tap (second_tap)
   );

   oatr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_sample_mem (
      .clock         (clock),
      .write_enable  (mem_write),
      .write_address (ADDR_BITS'(req_channel.table_address)),
      .write_data    (SAMPLE_BITS'(req_channel.table_data)),
      .read_address  (read_address),
      .read_data     (read_data)
   );

   oatr_mix u_mix (
      .clock      (clock),
      .ctrl       (mix_ctrl),
      .read_data  ($signed(read_data)),
      .first_tap  (first_tap),
      .second_tap (second_tap),
      .mix_sample (mix_sample)
   );

   // input handshake and table writes
   assign req_channel.ready = (state_ff == S_IDLE) && cfg.ready;
   assign accept    = req_channel.valid && req_channel.ready;
   assign mem_write = accept && req_channel.mode
                      && (32'(req_channel.table_address) < 32'(TABLE_DEPTH));
   assign slot_free = !rsp_valid_ff || rsp_channel.ready;

   // play sequencer
   always_comb begin
      state_in    = state_ff;
      silent_in   = silent_ff;
      position_in = position_ff;
      win_ctrl    = '0;
      mix_ctrl    = '0;
      read_address = first_tap.addr_lo;
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_channel.mode) begin
               position_in = req_channel.position;
               silent_in   = cfg.silent;
               state_in    = cfg.silent ? S_DONE : S_CALC;
            end
         end
         S_CALC: begin
            win_ctrl.restart = 1'b1;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            win_ctrl.advance = 1'b1;
            state_in = S_RD_A1;
         end
         S_RD_A1: begin
            read_address = first_tap.addr_lo;
            state_in = S_RD_B1;
         end
         S_RD_B1: begin
            read_address = first_tap.addr_hi;
            mix_ctrl.cap_a1 = 1'b1;
            state_in = S_RD_A2;
         end
         S_RD_A2: begin
            read_address = second_tap.addr_lo;
            mix_ctrl.cap_b1 = 1'b1;
            state_in = S_RD_B2;
         end
         S_RD_B2: begin
            read_address = second_tap.addr_hi;
            mix_ctrl.cap_a2 = 1'b1;
            mix_ctrl.mul_en = 1'b1;
            state_in = S_TAIL1;
         end
         S_TAIL1: begin
            mix_ctrl.cap_b2 = 1'b1;
            mix_ctrl.wgt_en = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mix_ctrl.mul_en = 1'b1;
            mix_ctrl.second = 1'b1;
            state_in = S_WGT2;
         end
         S_WGT2: begin
            mix_ctrl.wgt_en = 1'b1;
            mix_ctrl.second = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = silent_ff ? '0 : 16'(mix_sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      silent_ff     <= silent_in;
      position_ff   <= position_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.sample_out = rsp_sample_ff;

endmodule

`default_nettype wire
